// ===== rtl/fpl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpl_pkg
// shared types and constants of the flash page loader protocol unit
// ----------------------------------------------------------------------------
package fpl_pkg;

   localparam int DATA_W     = 8;
   localparam int HADDR_W    = 16;
   localparam int PAGE_NUM_W = 15;
   localparam int WORD_W     = 16;
   localparam int LIMIT_W    = 23;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 23'h007000;

   // command codes
   localparam logic [DATA_W-1:0] CMD_START = 8'h01;
   localparam logic [DATA_W-1:0] CMD_WRITE = 8'h02;

   // pad byte for short data packets
   localparam logic [DATA_W-1:0] FILL_BYTE = 8'hFF;

   // register index, taken from csr_paddr[2]
   localparam logic REG_BOOT_LIMIT = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_READ,
      ST_LOAD,
      ST_SOLO
   } fpl_state_type;

endpackage

// ===== rtl/fpl_page_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpl_page_ram
// page buffer: word-wide memory with byte writes, registered word read,
// per-byte valid bits so never-written bytes read as zero after reset
// ----------------------------------------------------------------------------
module fpl_page_ram #(
   parameter int PAGE_BYTES = 128
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      wr_en,
   input  logic [$clog2(PAGE_BYTES/2):0]             wr_addr,
   input  logic [fpl_pkg::DATA_W-1:0]                wr_data,
   input  logic                                      rd_en,
   input  logic [$clog2(PAGE_BYTES/2)-1:0]           rd_addr,
   output logic [fpl_pkg::WORD_W-1:0]                rd_data
);
   import fpl_pkg::*;

   localparam int WORDS  = PAGE_BYTES / 2;
   localparam int WADR_W = $clog2(WORDS);

   logic [WORD_W-1:0]     mem [WORDS];
   logic [PAGE_BYTES-1:0] valid_ff;
   logic [WORD_W-1:0]     rd_word_ff;
   logic [1:0]            rd_mask_ff;
   logic [WADR_W-1:0]     wr_word;

   assign wr_word = wr_addr[WADR_W:1];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         if (wr_addr[0]) begin
            mem[wr_word][WORD_W-1:DATA_W] <= wr_data;
         end else begin
            mem[wr_word][DATA_W-1:0] <= wr_data;
         end
      end
      if (rd_en) begin
         rd_word_ff <= mem[rd_addr];
         rd_mask_ff <= {valid_ff[{rd_addr, 1'b1}], valid_ff[{rd_addr, 1'b0}]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = {rd_mask_ff[1] ? rd_word_ff[WORD_W-1:DATA_W] : {DATA_W{1'b0}},
                     rd_mask_ff[0] ? rd_word_ff[DATA_W-1:0]      : {DATA_W{1'b0}}};

endmodule

// ===== rtl/fpl_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpl_ctrl
// packet parser and page sequencer: byte writes, pad sweep, word read-out
// ----------------------------------------------------------------------------
module fpl_ctrl #(
   parameter int PAGE_BYTES = 128
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [fpl_pkg::LIMIT_W-1:0]           boot_limit,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [fpl_pkg::DATA_W-1:0]            req_data_byte,
   input  logic                                  req_packet_end,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_word_valid,
   output logic [fpl_pkg::PAGE_NUM_W-1:0]        rsp_page_number,
   output logic [$clog2(PAGE_BYTES/2)-1:0]       rsp_word_index,
   output logic [fpl_pkg::WORD_W-1:0]            rsp_word_value,
   output logic                                  rsp_start_app,
   output logic                                  rsp_last,
   output logic                                  ram_wr_en,
   output logic [$clog2(PAGE_BYTES/2):0]         ram_wr_addr,
   output logic [fpl_pkg::DATA_W-1:0]            ram_wr_data,
   output logic                                  ram_rd_en,
   output logic [$clog2(PAGE_BYTES/2)-1:0]       ram_rd_addr,
   input  logic [fpl_pkg::WORD_W-1:0]            ram_rd_data
);
   import fpl_pkg::*;

   localparam int HALF    = PAGE_BYTES / 2;
   localparam int WORDS   = PAGE_BYTES / 2;
   localparam int WIDX_W  = $clog2(WORDS);
   localparam int ADDR_W  = WIDX_W + 1;
   localparam int POS_W   = $clog2(HALF + 1);
   localparam int PROD_W  = PAGE_NUM_W + 1 + $clog2(PAGE_BYTES + 1);
   localparam int CMP_W   = (PROD_W > LIMIT_W) ? PROD_W : LIMIT_W;

   fpl_state_type          state_ff, state_in;
   logic                   expect_ff, expect_in;
   logic [DATA_W-1:0]      cmd_ff, cmd_in;
   logic [HADDR_W-1:0]     addr_ff, addr_in;
   logic                   pending_ff, pending_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [POS_W-1:0]       fill_ff, fill_in;
   logic [WIDX_W-1:0]      widx_ff, widx_in;
   logic                   emit_ff, emit_in;
   logic                   emit_start_ff, emit_start_in;

   logic                   out_valid_ff, out_valid_in;
   logic                   out_load;
   logic                   out_wvalid_in, out_start_in, out_last_in;
   logic [PAGE_NUM_W-1:0]  out_page_in;
   logic [WIDX_W-1:0]      out_idx_in;
   logic [WORD_W-1:0]      out_value_in;
   logic                   out_wvalid_ff, out_start_ff, out_last_ff;
   logic [PAGE_NUM_W-1:0]  out_page_ff;
   logic [WIDX_W-1:0]      out_idx_ff;
   logic [WORD_W-1:0]      out_value_ff;

   logic                   out_free;
   logic                   pos_room;
   logic [POS_W-1:0]       pos_next;
   logic [DATA_W-1:0]      cmd_eff;
   logic [ADDR_W-1:0]      half_base;
   logic [CMP_W-1:0]       page_end;
   logic                   page_fits;
   logic                   word_last;

   // byte offset of the half selected by the address parity
   assign half_base = addr_ff[0] ? ADDR_W'(HALF) : '0;
   assign pos_room  = (pos_ff < POS_W'(HALF));
   assign pos_next  = pos_room ? (pos_ff + POS_W'(1)) : pos_ff;
   assign cmd_eff   = (pos_ff == '0) ? req_data_byte : cmd_ff;
   assign page_end  = CMP_W'(({1'b0, addr_ff[HADDR_W-1:1]} + (PAGE_NUM_W + 1)'(1))
                      * PROD_W'(PAGE_BYTES));
   assign page_fits = (page_end <= CMP_W'(boot_limit));
   assign word_last = (widx_ff == WIDX_W'(WORDS - 1));
   assign out_free  = !out_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         expect_ff     <= 1'b0;
         cmd_ff        <= '0;
         addr_ff       <= '0;
         pending_ff    <= 1'b0;
         pos_ff        <= '0;
         fill_ff       <= '0;
         widx_ff       <= '0;
         emit_ff       <= 1'b0;
         emit_start_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         expect_ff     <= expect_in;
         cmd_ff        <= cmd_in;
         addr_ff       <= addr_in;
         pending_ff    <= pending_in;
         pos_ff        <= pos_in;
         fill_ff       <= fill_in;
         widx_ff       <= widx_in;
         emit_ff       <= emit_in;
         emit_start_ff <= emit_start_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_wvalid_ff <= out_wvalid_in;
         out_page_ff   <= out_page_in;
         out_idx_ff    <= out_idx_in;
         out_value_ff  <= out_value_in;
         out_start_ff  <= out_start_in;
         out_last_ff   <= out_last_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      expect_in     = expect_ff;
      cmd_in        = cmd_ff;
      addr_in       = addr_ff;
      pending_in    = pending_ff;
      pos_in        = pos_ff;
      fill_in       = fill_ff;
      widx_in       = widx_ff;
      emit_in       = emit_ff;
      emit_start_in = emit_start_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_load      = 1'b0;
      out_wvalid_in = 1'b0;
      out_page_in   = '0;
      out_idx_in    = '0;
      out_value_in  = '0;
      out_start_in  = 1'b0;
      out_last_in   = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = half_base + ADDR_W'(pos_ff);
      ram_wr_data   = req_data_byte;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = widx_ff;
      req_stall     = (state_ff != ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (expect_ff) begin
                  ram_wr_en = pos_room;
               end else if (pos_ff == '0) begin
                  cmd_in = req_data_byte;
                  if (req_data_byte == CMD_WRITE) begin
                     addr_in = '0;
                  end
               end else if (cmd_ff == CMD_WRITE) begin
                  if (pos_ff == POS_W'(1)) begin
                     addr_in[DATA_W-1:0] = req_data_byte;
                  end else if (pos_ff == POS_W'(2)) begin
                     addr_in[HADDR_W-1:DATA_W] = req_data_byte;
                  end
               end
               pos_in = pos_next;

               if (req_packet_end) begin
                  pos_in        = '0;
                  fill_in       = pos_next;
                  widx_in       = '0;
                  emit_start_in = 1'b0;
                  if (expect_ff) begin
                     expect_in = 1'b0;
                     cmd_in    = '0;
                     if (addr_ff[0]) begin
                        pending_in = 1'b0;
                        emit_in    = page_fits;
                     end else begin
                        pending_in = 1'b1;
                        emit_in    = 1'b0;
                     end
                     if (pos_next < POS_W'(HALF)) begin
                        state_in = ST_FILL;
                     end else if (addr_ff[0] && page_fits) begin
                        state_in = ST_READ;
                     end
                  end else if (cmd_eff == CMD_WRITE) begin
                     expect_in = 1'b1;
                  end else if (cmd_eff == CMD_START) begin
                     if (pending_ff) begin
                        pending_in    = 1'b0;
                        emit_start_in = 1'b1;
                        state_in      = ST_READ;
                     end else begin
                        state_in = ST_SOLO;
                     end
                  end
               end
            end
         end

         ST_FILL: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = half_base + ADDR_W'(fill_ff);
            ram_wr_data = FILL_BYTE;
            fill_in     = fill_ff + POS_W'(1);
            if (fill_ff == POS_W'(HALF - 1)) begin
               state_in = emit_ff ? ST_READ : ST_IDLE;
            end
         end

         ST_READ: begin
            ram_rd_en = 1'b1;
            state_in  = ST_LOAD;
         end

         ST_LOAD: begin
            if (out_free) begin
               out_load      = 1'b1;
               out_valid_in  = 1'b1;
               out_wvalid_in = 1'b1;
               out_page_in   = addr_ff[HADDR_W-1:1];
               out_idx_in    = widx_ff;
               out_value_in  = ram_rd_data;
               out_last_in   = word_last;
               out_start_in  = word_last && emit_start_ff;
               widx_in       = widx_ff + WIDX_W'(1);
               state_in      = word_last ? ST_IDLE : ST_READ;
            end
         end

         ST_SOLO: begin
            if (out_free) begin
               out_load     = 1'b1;
               out_valid_in = 1'b1;
               out_start_in = 1'b1;
               out_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_word_valid  = out_wvalid_ff;
   assign rsp_page_number = out_page_ff;
   assign rsp_word_index  = out_idx_ff;
   assign rsp_word_value  = out_value_ff;
   assign rsp_start_app   = out_start_ff;
   assign rsp_last        = out_last_ff;

endmodule

// ===== rtl/flash_page_loader_protocol_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flash_page_loader_protocol_unit
// turns a stream of packet bytes into flash page program words
// ----------------------------------------------------------------------------
// Packet bytes come in one beat at a time on req_, each beat with its end-of-
// packet mark; page words and the start-application event leave on rsp_. A
// byte that does not end a packet is taken without holding input off, and so
// is the end of a command packet other than a start. A start with no pending
// half holds input off until its single beat is loaded into the output
// register. A data packet's end pads the rest of the half with 0xff at one
// byte a cycle (PAGE_BYTES/2 minus the bytes received). When a whole page is
// due, after an odd half that fits under boot_limit or a start with an even
// half pending, the block reads the page buffer through its single read port
// and loads each word into the output register before it reads the next, so
// an emitted page holds input off until its last word is loaded, which
// rsp_stall can delay. The page buffer reads as all zero after reset without
// any clearing pass. boot_limit sits at byte address 0 of the csr_ port and
// may only be written while idle.
// ----------------------------------------------------------------------------
module flash_page_loader_protocol_unit #(
   parameter int PAGE_BYTES = 128
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration port
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [fpl_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [fpl_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [fpl_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                  csr_pready,
   // packet byte beats
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [fpl_pkg::DATA_W-1:0]            req_data_byte,
   input  logic                                  req_packet_end,
   // result beats
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_word_valid,
   output logic [fpl_pkg::PAGE_NUM_W-1:0]        rsp_page_number,
   output logic [$clog2(PAGE_BYTES/2)-1:0]       rsp_word_index,
   output logic [fpl_pkg::WORD_W-1:0]            rsp_word_value,
   output logic                                  rsp_start_app,
   output logic                                  rsp_last
);
   import fpl_pkg::*;

   localparam int WIDX_W = $clog2(PAGE_BYTES / 2);

   logic [LIMIT_W-1:0] boot_limit_ff, boot_limit_in;
   logic               csr_write;
   logic               csr_hit;

   logic               ram_wr_en;
   logic [WIDX_W:0]    ram_wr_addr;
   logic [DATA_W-1:0]  ram_wr_data;
   logic               ram_rd_en;
   logic [WIDX_W-1:0]  ram_rd_addr;
   logic [WORD_W-1:0]  ram_rd_data;

   // apb access phase completes with no wait states
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   // register index is the word address; only the boot limit exists
   assign csr_hit    = (csr_paddr[2] == REG_BOOT_LIMIT) && (csr_paddr[1:0] == 2'b00);

   always_comb begin
      boot_limit_in = boot_limit_ff;
      if (csr_write && csr_hit) begin
         boot_limit_in = csr_pwdata[LIMIT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         boot_limit_ff <= LIMIT_RESET;
      end else begin
         boot_limit_ff <= boot_limit_in;
      end
   end

   // read back: boot limit zero extended, everything else reads zero
   assign csr_prdata = csr_hit ? CSR_DATA_W'(boot_limit_ff) : '0;

   // protocol parser, pad sweep and page read-out sequencer
   fpl_ctrl #(
      .PAGE_BYTES (PAGE_BYTES)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .boot_limit      (boot_limit_ff),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_packet_end  (req_packet_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_word_valid  (rsp_word_valid),
      .rsp_page_number (rsp_page_number),
      .rsp_word_index  (rsp_word_index),
      .rsp_word_value  (rsp_word_value),
      .rsp_start_app   (rsp_start_app),
      .rsp_last        (rsp_last),
      .ram_wr_en       (ram_wr_en),
      .ram_wr_addr     (ram_wr_addr),
      .ram_wr_data     (ram_wr_data),
      .ram_rd_en       (ram_rd_en),
      .ram_rd_addr     (ram_rd_addr),
      .ram_rd_data     (ram_rd_data)
   );

   // page buffer, byte writes in, little-endian words out
   fpl_page_ram #(
      .PAGE_BYTES (PAGE_BYTES)
   ) u_page_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

// ===== rtl/fpl_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpl_checker
// port-level checks of the result stream, bound to the top level
// ----------------------------------------------------------------------------
module fpl_checker #(
   parameter int PAGE_BYTES = 128
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic                                  rsp_word_valid,
   input  logic [fpl_pkg::PAGE_NUM_W-1:0]        rsp_page_number,
   input  logic [$clog2(PAGE_BYTES/2)-1:0]       rsp_word_index,
   input  logic [fpl_pkg::WORD_W-1:0]            rsp_word_value,
   input  logic                                  rsp_start_app,
   input  logic                                  rsp_last
);
   import fpl_pkg::*;

   localparam int WIDX_W = $clog2(PAGE_BYTES / 2);

   // a stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word_value)
         && $stable(rsp_word_index) && $stable(rsp_last))
      else $error("result beat changed under stall");

   // start only on the final beat of its command
   a_start_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_start_app |-> rsp_last)
      else $error("start_app without last");

   // a beat without a word is the lone start beat, all fields zero
   a_solo_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word_valid |-> rsp_start_app && rsp_last
         && (rsp_page_number == '0) && (rsp_word_index == '0) && (rsp_word_value == '0))
      else $error("bad start-only beat");

   // a page ends exactly on its final word
   a_page_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word_valid |->
         (rsp_last == (rsp_word_index == WIDX_W'(PAGE_BYTES / 2 - 1))))
      else $error("last mark does not match final word");

endmodule

bind flash_page_loader_protocol_unit fpl_checker #(
   .PAGE_BYTES (PAGE_BYTES)
) u_fpl_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_word_valid  (rsp_word_valid),
   .rsp_page_number (rsp_page_number),
   .rsp_word_index  (rsp_word_index),
   .rsp_word_value  (rsp_word_value),
   .rsp_start_app   (rsp_start_app),
   .rsp_last        (rsp_last)
);
